@@ rtl/uri_pkg.sv @@
// Shared types, constants and helper functions for the unicycle rollout integrator.
// No dependencies.
package uri_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_MUL_P,
        ST_MUL_KLO,
        ST_MUL_KHI,
        ST_TURN,
        ST_ANGLE,
        ST_CORDIC,
        ST_FIX,
        ST_MCX_LO,
        ST_MCX_HI,
        ST_MSY_LO,
        ST_MSY_HI,
        ST_SUM_Y,
        ST_POS_Y,
        ST_DONE
    } uri_state_t;

    typedef enum logic [2:0] {
        CFG_LIN_MIN,
        CFG_LIN_MAX,
        CFG_ANG_MAX,
        CFG_LIN_STEP_LOW,
        CFG_LIN_STEP_HIGH,
        CFG_ANG_STEP_MAX,
        CFG_STEP_TIME
    } uri_cfg_t;

    localparam logic        KIND_START = 1'b0;

    // rad/s * s (Q4.28) to binary angle with 16 fraction bits, 8/pi in Q28
    localparam logic [29:0] TURN_K     = 30'd683565276;
    localparam logic [16:0] TURN_K_LO  = {2'b00, TURN_K[14:0]};
    localparam logic [16:0] TURN_K_HI  = {2'b00, TURN_K[29:15]};

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] QUARTER     = 32'sd1073741824;
    localparam logic [63:0]        RND_TURN    = 64'd1 << 27;
    localparam logic [63:0]        RND_POS     = 64'd1 << 41;

    function automatic logic signed [31:0] cordic_atan(input logic [3:0] i);
        logic signed [31:0] a;
        unique case (i)
            4'd0:  a = 32'sd536870912;
            4'd1:  a = 32'sd316933406;
            4'd2:  a = 32'sd167458907;
            4'd3:  a = 32'sd85004756;
            4'd4:  a = 32'sd42667331;
            4'd5:  a = 32'sd21354465;
            4'd6:  a = 32'sd10679838;
            4'd7:  a = 32'sd5340245;
            4'd8:  a = 32'sd2670163;
            4'd9:  a = 32'sd1335087;
            4'd10: a = 32'sd667544;
            4'd11: a = 32'sd333772;
            4'd12: a = 32'sd166886;
            4'd13: a = 32'sd83443;
            4'd14: a = 32'sd41722;
            4'd15: a = 32'sd20861;
        endcase
        return a;
    endfunction

    // target clamp, then per-step change clamp, then 16-bit saturation
    function automatic logic signed [15:0] speed_advance(
        input logic signed [15:0] cur,
        input logic signed [15:0] tgt,
        input logic signed [16:0] tlo,
        input logic signed [16:0] thi,
        input logic signed [16:0] dlo,
        input logic signed [16:0] dhi
    );
        logic signed [16:0] t;
        logic signed [17:0] d;
        logic signed [17:0] n;
        logic signed [15:0] r;
        t = {tgt[15], tgt};
        if (t < tlo)
        begin
            t = tlo;
        end
        if (t > thi)
        begin
            t = thi;
        end
        d = {t[16], t} - {{2{cur[15]}}, cur};
        if (d < $signed({dlo[16], dlo}))
        begin
            d = {dlo[16], dlo};
        end
        if (d > $signed({dhi[16], dhi}))
        begin
            d = {dhi[16], dhi};
        end
        n = {{2{cur[15]}}, cur} + d;
        if (n > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (n < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = n[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/unicycle_rollout_integrator.sv @@
// Unicycle rollout integrator: one shared 32x17 multiplier and a 16-step CORDIC under a
// sequencer. Depends on uri_pkg.
// A step word goes through the speed limit, the 16 CORDIC iterations and eight passes
// through the multiplier before its result is loaded; a start word is loaded directly.
// Flow: one word at a time; in_stall is high from acceptance until the result is loaded.
// Reset: pose and speeds zero, registers at their defaults.
module unicycle_rollout_integrator
    import uri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [15:0] start_yaw,
    input  logic signed [15:0] start_vx,
    input  logic signed [15:0] start_wz,
    input  logic signed [15:0] target_vx,
    input  logic signed [15:0] target_wz,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [15:0] out_yaw,
    output logic signed [15:0] out_vx,
    output logic signed [15:0] out_wz,
    output logic               out_is_start
);

    uri_state_t state_reg, state_next;

    logic signed [15:0] lin_min_reg, lin_max_reg, lin_step_low_reg, lin_step_high_reg;
    logic [14:0]        ang_max_reg, ang_step_max_reg;
    logic [15:0]        step_time_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;
    logic signed [15:0] lin_speed_reg, ang_speed_reg;
    logic [3:0]         it_reg;
    logic               is_start_reg;
    logic               out_valid_reg;

    logic signed [15:0] tvx_reg, twz_reg;
    logic signed [31:0] op_reg;
    logic [48:0]        mul_reg;
    logic [63:0]        acc_reg, dsum_reg;
    logic [32:0]        turn_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic               neg_reg;

    logic signed [31:0] out_x_reg, out_y_reg;
    logic [15:0]        out_yaw_reg;
    logic signed [15:0] out_vx_reg, out_wz_reg;
    logic               out_is_start_reg;

    logic               in_take, out_take, out_load;
    logic [31:0]        mul_a;
    logic [16:0]        mul_b;
    logic [48:0]        mul_prod;
    logic [63:0]        mul_ext, acc_ext_sum15, acc_ext_sum16;
    logic [31:0]        base_ang, mid_ang, head_sum;
    logic signed [31:0] mid_s;
    logic signed [31:0] xs, ys, atan_i;
    logic signed [21:0] dpos;
    logic signed [32:0] pos_x_sum, pos_y_sum;
    logic signed [15:0] vx_new, wz_new;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (kind == KIND_START) ? ST_DONE : ST_LIMIT;
                end
            end
            ST_LIMIT:   state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_MUL_KLO;
            ST_MUL_KLO: state_next = ST_MUL_KHI;
            ST_MUL_KHI: state_next = ST_TURN;
            ST_TURN:    state_next = ST_ANGLE;
            ST_ANGLE:   state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (it_reg == 4'd15)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:     state_next = ST_MCX_LO;
            ST_MCX_LO:  state_next = ST_MCX_HI;
            ST_MCX_HI:  state_next = ST_MSY_LO;
            ST_MSY_LO:  state_next = ST_MSY_HI;
            ST_MSY_HI:  state_next = ST_SUM_Y;
            ST_SUM_Y:   state_next = ST_POS_Y;
            ST_POS_Y:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        mul_a    = op_reg;
        mul_b    = 17'd0;
        unique case (state_reg)
            ST_MUL_P:
            begin
                mul_a = {{16{ang_speed_reg[15]}}, ang_speed_reg};
                mul_b = {1'b0, step_time_reg};
            end
            ST_MUL_KLO:
            begin
                mul_a = mul_reg[31:0];
                mul_b = TURN_K_LO;
            end
            ST_MUL_KHI: mul_b = TURN_K_HI;
            ST_TURN:
            begin
                mul_a = {{16{lin_speed_reg[15]}}, lin_speed_reg};
                mul_b = {1'b0, step_time_reg};
            end
            ST_MCX_LO:  mul_b = {1'b0, x_reg[15:0]};
            ST_MCX_HI:  mul_b = {x_reg[31], x_reg[31:16]};
            ST_MSY_LO:  mul_b = {1'b0, y_reg[15:0]};
            ST_MSY_HI:  mul_b = {y_reg[31], y_reg[31:16]};
            default:
            begin
                mul_a = op_reg;
                mul_b = 17'd0;
            end
        endcase
    end

    assign mul_prod      = {{17{mul_a[31]}}, mul_a} * {{32{mul_b[16]}}, mul_b};
    assign mul_ext       = {{15{mul_reg[48]}}, mul_reg};
    assign acc_ext_sum15 = acc_reg + (mul_ext << 15);
    assign acc_ext_sum16 = acc_reg + (mul_ext << 16);

    assign base_ang = {heading_reg, 16'h0000};
    assign mid_ang  = base_ang + turn_reg[32:1];
    assign head_sum = base_ang + turn_reg[31:0] + 32'h0000_8000;
    assign mid_s    = mid_ang;

    assign xs     = x_reg >>> it_reg;
    assign ys     = y_reg >>> it_reg;
    assign atan_i = cordic_atan(it_reg);

    assign dpos      = dsum_reg[63:42];
    assign pos_x_sum = {pos_x_reg[31], pos_x_reg} + {{11{dpos[21]}}, dpos};
    assign pos_y_sum = {pos_y_reg[31], pos_y_reg} + {{11{dpos[21]}}, dpos};

    assign vx_new = speed_advance(lin_speed_reg, tvx_reg,
                                  {lin_min_reg[15], lin_min_reg},
                                  {lin_max_reg[15], lin_max_reg},
                                  {lin_step_low_reg[15], lin_step_low_reg},
                                  {lin_step_high_reg[15], lin_step_high_reg});
    assign wz_new = speed_advance(ang_speed_reg, twz_reg,
                                  -$signed({2'b00, ang_max_reg}),
                                  $signed({2'b00, ang_max_reg}),
                                  -$signed({2'b00, ang_step_max_reg}),
                                  $signed({2'b00, ang_step_max_reg}));

    // control, configuration and trajectory state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            lin_min_reg       <= 16'sd0;
            lin_max_reg       <= 16'sd4096;
            ang_max_reg       <= 15'd8192;
            lin_step_low_reg  <= -16'sd410;
            lin_step_high_reg <= 16'sd410;
            ang_step_max_reg  <= 15'd819;
            step_time_reg     <= 16'd3277;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            heading_reg       <= '0;
            lin_speed_reg     <= '0;
            ang_speed_reg     <= '0;
            it_reg            <= '0;
            is_start_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LIN_MIN:       lin_min_reg       <= cfg_data;
                    CFG_LIN_MAX:       lin_max_reg       <= cfg_data;
                    CFG_ANG_MAX:       ang_max_reg       <= cfg_data[14:0];
                    CFG_LIN_STEP_LOW:  lin_step_low_reg  <= cfg_data;
                    CFG_LIN_STEP_HIGH: lin_step_high_reg <= cfg_data;
                    CFG_ANG_STEP_MAX:  ang_step_max_reg  <= cfg_data[14:0];
                    CFG_STEP_TIME:     step_time_reg     <= cfg_data;
                    default:           ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        is_start_reg <= (kind == KIND_START);
                        if (kind == KIND_START)
                        begin
                            pos_x_reg     <= start_x;
                            pos_y_reg     <= start_y;
                            heading_reg   <= start_yaw;
                            lin_speed_reg <= start_vx;
                            ang_speed_reg <= start_wz;
                        end
                    end
                end
                ST_LIMIT:
                begin
                    lin_speed_reg <= vx_new;
                    ang_speed_reg <= wz_new;
                end
                ST_ANGLE:
                begin
                    heading_reg <= head_sum[31:16];
                    it_reg      <= '0;
                end
                ST_CORDIC:  it_reg <= it_reg + 4'd1;
                ST_MSY_HI:
                begin
                    if (pos_x_sum[32] != pos_x_sum[31])
                    begin
                        pos_x_reg <= pos_x_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        pos_x_reg <= pos_x_sum[31:0];
                    end
                end
                ST_POS_Y:
                begin
                    if (pos_y_sum[32] != pos_y_sum[31])
                    begin
                        pos_y_reg <= pos_y_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        pos_y_reg <= pos_y_sum[31:0];
                    end
                end
                default:    ;
            endcase
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_prod;

        if (in_take)
        begin
            tvx_reg <= target_vx;
            twz_reg <= target_wz;
        end

        if (out_load)
        begin
            out_x_reg        <= pos_x_reg;
            out_y_reg        <= pos_y_reg;
            out_yaw_reg      <= heading_reg;
            out_vx_reg       <= lin_speed_reg;
            out_wz_reg       <= ang_speed_reg;
            out_is_start_reg <= is_start_reg;
        end

        unique case (state_reg)
            ST_MUL_KLO: op_reg   <= mul_reg[31:0];
            ST_MUL_KHI: acc_reg  <= mul_ext + RND_TURN;
            ST_TURN:    turn_reg <= acc_ext_sum15[60:28];
            ST_ANGLE:
            begin
                op_reg  <= mul_reg[31:0];
                x_reg   <= CORDIC_GAIN;
                y_reg   <= '0;
                neg_reg <= (mid_s > QUARTER) || (mid_s < -QUARTER);
                if ((mid_s > QUARTER) || (mid_s < -QUARTER))
                begin
                    z_reg <= mid_s ^ 32'sh8000_0000;
                end
                else
                begin
                    z_reg <= mid_s;
                end
            end
            ST_CORDIC:
            begin
                if (!z_reg[31])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_i;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_i;
                end
            end
            ST_FIX:
            begin
                if (neg_reg)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end
            ST_MCX_HI:  acc_reg  <= mul_ext + RND_POS;
            ST_MSY_LO:  dsum_reg <= acc_ext_sum16;
            ST_MSY_HI:  acc_reg  <= mul_ext + RND_POS;
            ST_SUM_Y:   dsum_reg <= acc_ext_sum16;
            default:    ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_yaw      = out_yaw_reg;
    assign out_vx       = out_vx_reg;
    assign out_wz       = out_wz_reg;
    assign out_is_start = out_is_start_reg;

endmodule

@@ dv/unicycle_rollout_integrator_tb.sv @@
// Self-checking bench for unicycle_rollout_integrator: random and directed start/step words,
// bit-exact pose and speed prediction, random idling on both channels.
// Depends on rtl/uri_pkg.sv and rtl/unicycle_rollout_integrator.sv.
module unicycle_rollout_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uri_pkg::*;

    localparam logic       KIND_STEP  = 1'b1;
    localparam logic [2:0] CFG_SPARE  = 3'd7;

    localparam longint TURN_Q28     = 64'sd683565276;
    localparam longint TURN_RND     = 64'sd134217728;
    localparam longint POS_RND      = 64'sd2199023255552;
    localparam longint CORDIC_K     = 64'sd652032874;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint ATAN_STEPS [16] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
        64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
        64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
        64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861
    };

    typedef struct packed {
        logic        kind;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [15:0] syaw;
        logic [15:0] svx;
        logic [15:0] swz;
        logic [15:0] tvx;
        logic [15:0] twz;
    } word_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] yaw;
        logic [15:0] vx;
        logic [15:0] wz;
        logic        is_start;
    } pose_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [2:0]         cfg_index    = '0;
    logic [15:0]        cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               kind         = KIND_START;
    logic signed [31:0] start_x      = '0;
    logic signed [31:0] start_y      = '0;
    logic signed [15:0] start_yaw    = '0;
    logic signed [15:0] start_vx     = '0;
    logic signed [15:0] start_wz     = '0;
    logic signed [15:0] target_vx    = '0;
    logic signed [15:0] target_wz    = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_yaw;
    logic signed [15:0] out_vx;
    logic signed [15:0] out_wz;
    logic               out_is_start;

    // predictor copy of the registers and the pose
    logic signed [15:0] lin_min       = 16'sd0;
    logic signed [15:0] lin_max       = 16'sd4096;
    logic [14:0]        ang_max       = 15'd8192;
    logic signed [15:0] lin_step_low  = -16'sd410;
    logic signed [15:0] lin_step_high = 16'sd410;
    logic [14:0]        ang_step_max  = 15'd819;
    logic [15:0]        step_time     = 16'd3277;
    logic signed [31:0] pos_x         = '0;
    logic signed [31:0] pos_y         = '0;
    logic [15:0]        heading       = '0;
    logic signed [15:0] lin_speed     = '0;
    logic signed [15:0] ang_speed     = '0;

    word_t pending_words [$];
    pose_t predicted_poses [$];
    word_t offered;
    bit    in_fire       = 1'b0;
    bit    out_fire      = 1'b0;
    bit    send_pause    = 1'b0;
    int    send_wait     = 0;
    int    send_max_wait = 16;
    int    drain_wait    = 0;
    int    recv_max_wait = 16;
    int    recv_hold     = 0;
    int    fault_count   = 0;

    unicycle_rollout_integrator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_yaw    (start_yaw),
        .start_vx     (start_vx),
        .start_wz     (start_wz),
        .target_vx    (target_vx),
        .target_wz    (target_wz),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_yaw      (out_yaw),
        .out_vx       (out_vx),
        .out_wz       (out_wz),
        .out_is_start (out_is_start)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic log_fault(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fault_count++;
    endtask

    function automatic longint speed_limit(input longint cur, input longint tgt,
                                           input longint tlo, input longint thi,
                                           input longint dlo, input longint dhi);
        longint t;
        longint d;
        longint n;
        t = tgt;
        if (t < tlo)
        begin
            t = tlo;
        end
        if (t > thi)
        begin
            t = thi;
        end
        d = t - cur;
        if (d < dlo)
        begin
            d = dlo;
        end
        if (d > dhi)
        begin
            d = dhi;
        end
        n = cur + d;
        if (n > 32767)
        begin
            n = 32767;
        end
        if (n < -32768)
        begin
            n = -32768;
        end
        return n;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // rotation-mode CORDIC, angle in 1/2^32 turn, results Q1.30
    task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xn;
        bit     flip;
        int     i;
        z    = longint'($signed(ang));
        flip = 1'b0;
        x    = CORDIC_K;
        y    = 0;
        if (z > QUARTER_TURN)
        begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        for (i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_STEPS[i];
            end
            else
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_STEPS[i];
            end
            x = xn;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic integrate_word(input word_t w, output pose_t r);
        longint      vx;
        longint      wz;
        longint      dt;
        longint      turn;
        longint      c;
        longint      s;
        logic [31:0] base;
        logic [31:0] mid;
        logic [31:0] nh;
        if (w.kind == KIND_START)
        begin
            pos_x     = w.sx;
            pos_y     = w.sy;
            heading   = w.syaw;
            lin_speed = w.svx;
            ang_speed = w.swz;
        end
        else
        begin
            vx = speed_limit(longint'(lin_speed), longint'($signed(w.tvx)),
                             longint'(lin_min), longint'(lin_max),
                             longint'(lin_step_low), longint'(lin_step_high));
            wz = speed_limit(longint'(ang_speed), longint'($signed(w.twz)),
                             -longint'(ang_max), longint'(ang_max),
                             -longint'(ang_step_max), longint'(ang_step_max));
            dt   = longint'(step_time);
            turn = (wz * dt * TURN_Q28 + TURN_RND) >>> 28;
            base = {heading, 16'h0000};
            mid  = base + 32'(turn >>> 1);
            nh   = base + 32'(turn) + 32'd32768;
            rotate_unit(mid, c, s);
            pos_x     = 32'(sat32(longint'(pos_x) + ((vx * c * dt + POS_RND) >>> 42)));
            pos_y     = 32'(sat32(longint'(pos_y) + ((vx * s * dt + POS_RND) >>> 42)));
            heading   = nh[31:16];
            lin_speed = 16'(vx);
            ang_speed = 16'(wz);
        end
        r.x        = pos_x;
        r.y        = pos_y;
        r.yaw      = heading;
        r.vx       = lin_speed;
        r.wz       = ang_speed;
        r.is_start = (w.kind == KIND_START);
    endtask

    // acceptance on both channels; check first so an empty queue is caught
    always @(posedge clk)
    begin
        pose_t want;
        pose_t next_pose;
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (out_fire)
        begin
            if (predicted_poses.size() == 0)
            begin
                log_fault($sformatf("result word with none expected, x %h", out_x));
            end
            else
            begin
                want = predicted_poses.pop_front();
                if (out_x !== want.x)
                    log_fault($sformatf("out_x got %h want %h", out_x, want.x));
                if (out_y !== want.y)
                    log_fault($sformatf("out_y got %h want %h", out_y, want.y));
                if (out_yaw !== want.yaw)
                    log_fault($sformatf("out_yaw got %h want %h", out_yaw, want.yaw));
                if (out_vx !== want.vx)
                    log_fault($sformatf("out_vx got %h want %h", out_vx, want.vx));
                if (out_wz !== want.wz)
                    log_fault($sformatf("out_wz got %h want %h", out_wz, want.wz));
                if (out_is_start !== want.is_start)
                    log_fault($sformatf("out_is_start got %b want %b",
                                        out_is_start, want.is_start));
            end
        end
        if (in_fire)
        begin
            integrate_word(offered, next_pose);
            predicted_poses = {predicted_poses, next_pose};
        end
    end

    always @(negedge clk)
    begin
        word_t w;
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                in_valid <= 1'b0;
            end
            else if (!send_pause && pending_words.size() > 0)
            begin
                w         = pending_words.pop_front();
                offered   = w;
                kind      <= w.kind;
                start_x   <= w.sx;
                start_y   <= w.sy;
                start_yaw <= w.syaw;
                start_vx  <= w.svx;
                start_wz  <= w.swz;
                target_vx <= w.tvx;
                target_wz <= w.twz;
                in_valid  <= 1'b1;
                send_wait = $urandom_range(0, send_max_wait);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                drain_wait = $urandom_range(0, recv_max_wait);
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else if (drain_wait > 0)
            begin
                drain_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [15:0] pick16();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3, 4: v = 16'($urandom_range(0, 16383)) - 16'd8192;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick32();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2, 3, 4: v = 32'($urandom_range(0, 6553600)) - 32'd3276800;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic word_t blank_word();
        word_t w;
        w.kind = 1'($urandom);
        w.sx   = $urandom;
        w.sy   = $urandom;
        w.syaw = 16'($urandom);
        w.svx  = 16'($urandom);
        w.swz  = 16'($urandom);
        w.tvx  = 16'($urandom);
        w.twz  = 16'($urandom);
        return w;
    endfunction

    task automatic push_start(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] yaw, input logic [15:0] vx,
                              input logic [15:0] wz);
        word_t w;
        w      = blank_word();
        w.kind = KIND_START;
        w.sx   = x;
        w.sy   = y;
        w.syaw = yaw;
        w.svx  = vx;
        w.swz  = wz;
        pending_words = {pending_words, w};
    endtask

    task automatic push_step(input logic [15:0] tvx, input logic [15:0] twz);
        word_t w;
        w      = blank_word();
        w.kind = KIND_STEP;
        w.tvx  = tvx;
        w.twz  = twz;
        pending_words = {pending_words, w};
    endtask

    // mostly start-then-steps rollouts, some lone words
    task automatic random_phase(input int count);
        int made;
        int len;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                pending_words = {pending_words, blank_word()};
                made++;
            end
            else
            begin
                len = $urandom_range(1, 20);
                push_start(pick32(), pick32(), pick16(), pick16(), pick16());
                repeat (len) push_step(pick16(), pick16());
                made += len + 1;
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LIN_MIN:       lin_min       = val;
            CFG_LIN_MAX:       lin_max       = val;
            CFG_ANG_MAX:       ang_max       = val[14:0];
            CFG_LIN_STEP_LOW:  lin_step_low  = val;
            CFG_LIN_STEP_HIGH: lin_step_high = val;
            CFG_ANG_STEP_MAX:  ang_step_max  = val[14:0];
            CFG_STEP_TIME:     step_time     = val;
            default:           ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] lmin, input logic [15:0] lmax,
                                 input logic [15:0] amax, input logic [15:0] slo,
                                 input logic [15:0] shi, input logic [15:0] samax,
                                 input logic [15:0] dt);
        write_reg(CFG_LIN_MIN, lmin);
        write_reg(CFG_LIN_MAX, lmax);
        write_reg(CFG_ANG_MAX, amax);
        write_reg(CFG_LIN_STEP_LOW, slo);
        write_reg(CFG_LIN_STEP_HIGH, shi);
        write_reg(CFG_ANG_STEP_MAX, samax);
        write_reg(CFG_STEP_TIME, dt);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_setting();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] dt;
        a = pick16();
        b = pick16();
        if (($signed(a) > $signed(b)) != ($urandom_range(0, 5) == 0))
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
        a  = -16'($urandom_range(0, 4000));
        b  = 16'($urandom_range(0, 4000));
        dt = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 5) == 0)
        begin
            apply_setting(lo, hi, 16'($urandom), b, a, 16'($urandom), dt);
        end
        else
        begin
            apply_setting(lo, hi, 16'($urandom), a, b, 16'($urandom_range(0, 4000)), dt);
        end
    endtask

    task automatic set_pace(input int s, input int r);
        @(posedge clk);
        send_max_wait = s;
        recv_max_wait = r;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || predicted_poses.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits
        set_pace(16, 16);
        push_start(32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        push_step(16'h0000, 16'h0000);
        push_step(16'h7FFF, 16'h7FFF);
        push_step(16'h8000, 16'h8000);
        push_start(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h8000);
        push_step(16'h7FFF, 16'h7FFF);
        push_start(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h7FFF);
        push_step(16'h8000, 16'h8000);
        random_phase(300);
        @(posedge clk);
        recv_hold = 400;
        wait_idle();

        // widest limits, longest step
        write_reg(CFG_SPARE, 16'hFFFF);
        apply_setting(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        set_pace(0, 0);
        push_start(32'h0, 32'h0, 16'h4000, 16'h0, 16'h0);
        push_step(16'h7FFF, 16'h7FFF);
        push_step(16'h8000, 16'h8000);
        random_phase(300);
        repeat (1500) @(posedge clk);
        send_pause = 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (in_valid || predicted_poses.size() != 0);
        @(posedge clk);
        send_pause = 1'b0;
        wait_idle();

        // inverted limits and bounds, zero step time
        apply_setting(16'd3000, -16'd1000, 16'h0, 16'd500, -16'd200, 16'h0, 16'h0);
        set_pace(16, 0);
        push_start(32'h0001_0000, 32'hFFFF_0000, 16'h1234, 16'd2000, -16'd300);
        push_step(16'h7FFF, 16'h8000);
        push_step(16'h8000, 16'h7FFF);
        random_phase(200);
        wait_idle();

        // change bounds that push the speeds past full scale
        apply_setting(16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0001);
        set_pace(0, 16);
        push_start(32'h7FFF_FFF0, 32'h0, 16'h0, 16'h7FFF, 16'h7FFF);
        push_step(16'h7FFF, 16'h7FFF);
        push_step(16'h0000, 16'h0000);
        random_phase(200);
        wait_idle();

        apply_setting(16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
        set_pace(16, 16);
        push_start(32'h8000_0010, 32'h7FFF_FFF0, 16'h8000, 16'h8000, 16'h8000);
        push_step(16'h8000, 16'h8000);
        random_phase(200);
        wait_idle();

        repeat (4)
        begin
            random_setting();
            set_pace($urandom_range(0, 1) * 16, $urandom_range(0, 1) * 16);
            random_phase(175);
            wait_idle();
        end

        if (fault_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
